// ===== src/bcs_pkg.sv =====
// Shared types and constants for the barometric compensation sequencer.
// Used by bcs_mul, bcs_ctrl and barometric_compensation_sequencer_top; depends on nothing.
package bcs_pkg;

  // Pressure readings taken after each temperature reading.
  localparam int unsigned PressurePerTemp = 3;

  // Field and datapath widths.
  localparam int unsigned RawW   = 24;
  localparam int unsigned CalW   = 16;
  localparam int unsigned TempW  = 19;
  localparam int unsigned PresW  = 32;
  localparam int unsigned PhaseW = 2;
  localparam int unsigned DtW    = 25;
  localparam int unsigned OpW    = 26;
  localparam int unsigned ProdW  = 2 * OpW;
  localparam int unsigned WideW  = 48;
  localparam int unsigned AccW   = 64;
  localparam int unsigned CfgIdxW = 3;

  // Temperature thresholds in hundredths of a degree.
  localparam int TempRef     = 2000;
  localparam int TempVeryLow = -1500;

  // Calibration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_SENS_C1  = 3'd0,
    REG_OFF_C2   = 3'd1,
    REG_TCS_C3   = 3'd2,
    REG_TCO_C4   = 3'd3,
    REG_TREF_C5  = 3'd4,
    REG_TEMPS_C6 = 3'd5
  } cfg_reg_e;

  // Sequencer steps.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DT,
    ST_TMUL,
    ST_TEMP,
    ST_OFF,
    ST_SENS,
    ST_LOWCHK,
    ST_OFF2,
    ST_SENS2,
    ST_OFF3,
    ST_SENS3,
    ST_TFIX,
    ST_PLO,
    ST_PHI,
    ST_PACC,
    ST_PFIN,
    ST_DONE
  } state_e;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic is_pressure;
    logic low_temp;
    logic very_low_temp;
    logic out_free;
  } flags_t;

  // Controls from the sequencer to the datapath.
  typedef struct packed {
    state_e st;
    logic   in_ready;
    logic   mul_en;
    logic   out_load;
  } ctrl_t;

endpackage

// ===== src/barometric_compensation_sequencer_top.sv =====
// Top level of the barometric compensation sequencer: ports, calibration registers and datapath.
// Depends on bcs_pkg, bcs_mul and bcs_ctrl.

// Each accepted word is one 24-bit conversion reading. The block expects one temperature
// reading and then three pressure readings, round and round, starting with temperature
// after reset. Every word gives one result word carrying the held temperature, the pressure
// (zero on a temperature word) and which conversion to start next. All products go through
// one 26 x 26 bit multiplier with a registered output, under a step sequencer, so the next
// word is taken only once the steps for the last one have run, where a temperature word
// below 20.00 C adds the second-order steps and one below -15.00 C the very-low steps too,
// and once the output register has been emptied. Calibration writes are taken at any edge
// but should only be made while the block is idle.
module barometric_compensation_sequencer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Calibration write port.
  input  logic                          cfg_we_i,
  input  logic [bcs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bcs_pkg::CalW-1:0]      cfg_data_i,
  // Input stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [23:0]                   s_axis_tdata,   // [23:0] raw_reading
  // Output stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [55:0]                   m_axis_tdata,   // [18:0] temperature_centi,
                                                        // [50:19] pressure_centi,
                                                        // [51] next_is_temperature
  output logic [0:0]                    m_axis_tuser    // [0] pressure_valid
);

  // Calibration registers.
  logic [bcs_pkg::CalW-1:0] c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
      c4_q <= '0;
      c5_q <= '0;
      c6_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bcs_pkg::REG_SENS_C1:  c1_q <= cfg_data_i;
        bcs_pkg::REG_OFF_C2:   c2_q <= cfg_data_i;
        bcs_pkg::REG_TCS_C3:   c3_q <= cfg_data_i;
        bcs_pkg::REG_TCO_C4:   c4_q <= cfg_data_i;
        bcs_pkg::REG_TREF_C5:  c5_q <= cfg_data_i;
        bcs_pkg::REG_TEMPS_C6: c6_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer.
  bcs_pkg::flags_t flags;
  bcs_pkg::ctrl_t  ctrl;

  bcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .flags_i    (flags),
    .ctrl_o     (ctrl)
  );

  assign s_axis_tready = ctrl.in_ready;

  // Working registers.
  logic [bcs_pkg::RawW-1:0]          raw_q;
  logic [bcs_pkg::PhaseW-1:0]        phase_q;
  logic signed [bcs_pkg::DtW-1:0]    dt_q;
  logic signed [bcs_pkg::TempW-1:0]  t_q;
  logic [bcs_pkg::TempW-2:0]         t2_q;
  logic signed [bcs_pkg::WideW-1:0]  off_q, sens_q;
  logic signed [bcs_pkg::AccW-1:0]   acc_q;
  logic [bcs_pkg::PresW-1:0]         pres_q;

  logic                              m_valid_q;
  logic [55:0]                       m_data_q;
  logic [0:0]                        m_user_q;

  logic signed [bcs_pkg::ProdW-1:0]  prod;

  // Narrow temperature differences for the correction squares.
  logic signed [bcs_pkg::TempW:0]    d_t, e_t;
  logic signed [bcs_pkg::TempW+3:0]  d5, e7, e11;

  assign d_t = {t_q[bcs_pkg::TempW-1], t_q} - (bcs_pkg::TempW+1)'(bcs_pkg::TempRef);
  assign e_t = {t_q[bcs_pkg::TempW-1], t_q} - (bcs_pkg::TempW+1)'(bcs_pkg::TempVeryLow);
  assign d5  = {{3{d_t[bcs_pkg::TempW]}}, d_t} + {d_t[bcs_pkg::TempW], d_t, 2'b00};
  assign e7  = {e_t, 3'b000} - {{3{e_t[bcs_pkg::TempW]}}, e_t};
  assign e11 = {e_t, 3'b000} + {{2{e_t[bcs_pkg::TempW]}}, e_t, 1'b0}
             + {{3{e_t[bcs_pkg::TempW]}}, e_t};

  // Multiplier operand selection.
  logic signed [bcs_pkg::OpW-1:0] op_a, op_b, dt_op, raw_op;

  assign dt_op  = {dt_q[bcs_pkg::DtW-1], dt_q};
  assign raw_op = {2'b00, raw_q};

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (ctrl.st)
      bcs_pkg::ST_TMUL: begin
        op_a = dt_op;
        op_b = {10'b0, c6_q};
      end
      bcs_pkg::ST_TEMP: begin
        op_a = dt_op;
        op_b = {10'b0, c4_q};
      end
      bcs_pkg::ST_OFF: begin
        op_a = dt_op;
        op_b = {10'b0, c3_q};
      end
      bcs_pkg::ST_SENS: begin
        op_a = dt_op;
        op_b = dt_op;
      end
      bcs_pkg::ST_LOWCHK: begin
        op_a = {{6{d_t[bcs_pkg::TempW]}}, d_t};
        op_b = {{3{d5[bcs_pkg::TempW+3]}}, d5};
      end
      bcs_pkg::ST_SENS2: begin
        op_a = {{6{e_t[bcs_pkg::TempW]}}, e_t};
        op_b = {{3{e7[bcs_pkg::TempW+3]}}, e7};
      end
      bcs_pkg::ST_OFF3: begin
        op_a = {{6{e_t[bcs_pkg::TempW]}}, e_t};
        op_b = {{3{e11[bcs_pkg::TempW+3]}}, e11};
      end
      bcs_pkg::ST_PLO: begin
        op_a = raw_op;
        op_b = {2'b00, sens_q[23:0]};
      end
      bcs_pkg::ST_PHI: begin
        op_a = raw_op;
        op_b = {{2{sens_q[bcs_pkg::WideW-1]}}, sens_q[bcs_pkg::WideW-1:24]};
      end
      default: ;
    endcase
  end

  bcs_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (ctrl.mul_en),
    .a_i    (op_a),
    .b_i    (op_b),
    .prod_o (prod)
  );

  // Shifted views of the product and the pressure difference.
  logic signed [bcs_pkg::ProdW-1:0] prod_sr1, prod_sr2, prod_sr7, prod_sr8;
  logic signed [bcs_pkg::AccW-1:0]  acc_sr21, pres_diff;

  assign prod_sr1  = prod >>> 1;
  assign prod_sr2  = prod >>> 2;
  assign prod_sr7  = prod >>> 7;
  assign prod_sr8  = prod >>> 8;
  assign acc_sr21  = acc_q >>> 21;
  assign pres_diff = acc_sr21 - {{16{off_q[bcs_pkg::WideW-1]}}, off_q};

  // Phase advance after each word.
  logic [bcs_pkg::PhaseW:0]   phase_inc;
  logic [bcs_pkg::PhaseW-1:0] phase_next;

  assign phase_inc  = {1'b0, phase_q} + (bcs_pkg::PhaseW+1)'(1);
  assign phase_next = (phase_inc > (bcs_pkg::PhaseW+1)'(bcs_pkg::PressurePerTemp))
                    ? '0 : phase_inc[bcs_pkg::PhaseW-1:0];

  // Status for the sequencer.
  assign flags.is_pressure   = (phase_q != '0);
  assign flags.low_temp      = (t_q < bcs_pkg::TempW'(bcs_pkg::TempRef));
  assign flags.very_low_temp = (t_q < bcs_pkg::TempW'(bcs_pkg::TempVeryLow));
  assign flags.out_free      = !m_valid_q || m_axis_tready;

  // Input word latch.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && ctrl.in_ready) begin
      raw_q <= s_axis_tdata;
    end
  end

  // Step results that are not compensation state.
  always_ff @(posedge clk_i) begin
    case (ctrl.st)
      bcs_pkg::ST_DT: begin
        dt_q <= $signed({1'b0, raw_q}) - $signed({1'b0, c5_q, 8'b0});
      end
      bcs_pkg::ST_LOWCHK: t2_q   <= prod[48:31];
      bcs_pkg::ST_PHI:    acc_q  <= {{12{prod[bcs_pkg::ProdW-1]}}, prod};
      bcs_pkg::ST_PACC:   acc_q  <= acc_q + {prod[39:0], 24'b0};
      bcs_pkg::ST_PFIN:   pres_q <= pres_diff[46:15];
      default: ;
    endcase
  end

  // Compensation state: temperature, offset and sensitivity.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_q    <= '0;
      off_q  <= '0;
      sens_q <= '0;
    end else begin
      case (ctrl.st)
        bcs_pkg::ST_TEMP:  t_q    <= prod[41:23] + bcs_pkg::TempW'(bcs_pkg::TempRef);
        bcs_pkg::ST_OFF:   off_q  <= {16'b0, c2_q, 16'b0} + prod_sr7[bcs_pkg::WideW-1:0];
        bcs_pkg::ST_SENS:  sens_q <= {17'b0, c1_q, 15'b0} + prod_sr8[bcs_pkg::WideW-1:0];
        bcs_pkg::ST_OFF2:  off_q  <= off_q - prod_sr1[bcs_pkg::WideW-1:0];
        bcs_pkg::ST_SENS2: sens_q <= sens_q - prod_sr2[bcs_pkg::WideW-1:0];
        bcs_pkg::ST_OFF3:  off_q  <= off_q - prod[bcs_pkg::WideW-1:0];
        bcs_pkg::ST_SENS3: sens_q <= sens_q - prod_sr1[bcs_pkg::WideW-1:0];
        bcs_pkg::ST_TFIX:  t_q    <= t_q - $signed({1'b0, t2_q});
        default: ;
      endcase
    end
  end

  // Phase counter and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (ctrl.out_load) begin
        phase_q   <= phase_next;
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Output word register.
  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      m_data_q <= {4'b0, (phase_next == '0), (flags.is_pressure ? pres_q : '0), t_q};
      m_user_q <= flags.is_pressure;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // The block takes no second word straight after accepting one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted on two consecutive edges");

  // A temperature result carries zero pressure.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[50:19] == '0))
    else $error("pressure given on a temperature word");

  // A temperature conversion is only requested after a pressure reading.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[51]) |-> m_axis_tuser[0])
    else $error("temperature requested after a temperature word");

  // The phase never runs past the last pressure reading.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= bcs_pkg::PhaseW'(bcs_pkg::PressurePerTemp))
    else $error("phase out of range");

endmodule

// ===== src/bcs_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on bcs_pkg for the operand width.
module bcs_mul (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [bcs_pkg::OpW-1:0]      a_i,
  input  logic signed [bcs_pkg::OpW-1:0]      b_i,
  output logic signed [bcs_pkg::ProdW-1:0]    prod_o
);

  logic signed [bcs_pkg::ProdW-1:0] prod_q;

  // The product holds when no new operation is issued.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== src/bcs_ctrl.sv =====
// Step sequencer that drives the shared multiplier and the datapath.
// Depends on bcs_pkg for the state enum and the control structs.
module bcs_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  bcs_pkg::flags_t flags_i,
  output bcs_pkg::ctrl_t  ctrl_o
);

  bcs_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bcs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next step.
  always_comb begin
    state_d = state_q;
    case (state_q)
      bcs_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = flags_i.is_pressure ? bcs_pkg::ST_PLO : bcs_pkg::ST_DT;
        end
      end
      bcs_pkg::ST_DT:     state_d = bcs_pkg::ST_TMUL;
      bcs_pkg::ST_TMUL:   state_d = bcs_pkg::ST_TEMP;
      bcs_pkg::ST_TEMP:   state_d = bcs_pkg::ST_OFF;
      bcs_pkg::ST_OFF:    state_d = bcs_pkg::ST_SENS;
      bcs_pkg::ST_SENS:   state_d = bcs_pkg::ST_LOWCHK;
      bcs_pkg::ST_LOWCHK: begin
        state_d = flags_i.low_temp ? bcs_pkg::ST_OFF2 : bcs_pkg::ST_DONE;
      end
      bcs_pkg::ST_OFF2:   state_d = bcs_pkg::ST_SENS2;
      bcs_pkg::ST_SENS2: begin
        state_d = flags_i.very_low_temp ? bcs_pkg::ST_OFF3 : bcs_pkg::ST_TFIX;
      end
      bcs_pkg::ST_OFF3:   state_d = bcs_pkg::ST_SENS3;
      bcs_pkg::ST_SENS3:  state_d = bcs_pkg::ST_TFIX;
      bcs_pkg::ST_TFIX:   state_d = bcs_pkg::ST_DONE;
      bcs_pkg::ST_PLO:    state_d = bcs_pkg::ST_PHI;
      bcs_pkg::ST_PHI:    state_d = bcs_pkg::ST_PACC;
      bcs_pkg::ST_PACC:   state_d = bcs_pkg::ST_PFIN;
      bcs_pkg::ST_PFIN:   state_d = bcs_pkg::ST_DONE;
      bcs_pkg::ST_DONE: begin
        if (flags_i.out_free) begin
          state_d = bcs_pkg::ST_IDLE;
        end
      end
      default:            state_d = bcs_pkg::ST_IDLE;
    endcase
  end

  // Outputs decoded from the current step.
  always_comb begin
    ctrl_o.st       = state_q;
    ctrl_o.in_ready = (state_q == bcs_pkg::ST_IDLE);
    ctrl_o.out_load = (state_q == bcs_pkg::ST_DONE) && flags_i.out_free;
    ctrl_o.mul_en   = state_q inside {bcs_pkg::ST_TMUL, bcs_pkg::ST_TEMP, bcs_pkg::ST_OFF,
                                      bcs_pkg::ST_SENS, bcs_pkg::ST_LOWCHK,
                                      bcs_pkg::ST_SENS2, bcs_pkg::ST_OFF3,
                                      bcs_pkg::ST_PLO, bcs_pkg::ST_PHI};
  end

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for barometric_compensation_sequencer_top.
// Depends on bcs_pkg and the RTL. A directed table of readings and calibration writes runs
// first, then random readings under random, full-scale or zero calibration, checked against a local predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bcs_pkg::*;

  localparam int unsigned                ClkHalf      = 5;
  localparam int unsigned                CycleLimit   = 400000;
  localparam int unsigned                HoldCycles   = 300;
  localparam int unsigned                PhaseWords   = 220;
  localparam int unsigned                RandPhases   = 8;
  localparam int unsigned                MaxReported  = 50;
  localparam logic [CfgIdxW-1:0]         RegSpareLo   = 3'd6;
  localparam logic [CfgIdxW-1:0]         RegSpareHi   = 3'd7;
  localparam int unsigned                NumCal       = 6;

  // One result word, by field.
  typedef struct {
    logic                     pressure_valid;
    logic signed [TempW-1:0]  temperature_centi;
    logic signed [PresW-1:0]  pressure_centi;
    logic                     next_is_temperature;
  } baro_result_t;

  typedef enum logic {ROW_WRITE, ROW_READING} row_kind_e;

  // One line of the directed part: a calibration write or a reading.
  typedef struct {
    row_kind_e            kind;
    logic [CfgIdxW-1:0]   idx;
    logic [CalW-1:0]      data;
    logic [RawW-1:0]      raw;
    bit                   typed;
    baro_result_t         res;
  } row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [CalW-1:0]      cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [23:0]          s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [55:0]          m_axis_tdata;
  logic [0:0]           m_axis_tuser;

  // Predictor state: calibration copy, reading phase and held compensation terms.
  logic [CalW-1:0]      cal_regs [NumCal];
  int unsigned          model_phase = 0;
  longint               held_temp   = 0;
  longint               held_off    = 0;
  longint               held_sens   = 0;

  baro_result_t         pending_readouts [$];
  row_t                 dir_rows [$];
  int unsigned          mismatches = 0;
  int unsigned          cycles     = 0;
  int unsigned          words_in   = 0;
  int unsigned          gap_pct    = 0;
  int unsigned          stall_pct  = 0;
  bit                   hold_req   = 1'b0;

  barometric_compensation_sequencer_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Temperature reading: second-order compensation terms are refreshed and held.
  // Pressure reading: compensated pressure from the held terms.
  function automatic baro_result_t compensate_reading(input logic [RawW-1:0] raw);
    baro_result_t r;
    longint       rv, dt, t, off, sens, t2, d, f, off2, sens2, e, f2, p;
    rv = longint'(raw);
    p  = 0;
    r.pressure_valid = 1'b0;
    if (model_phase == 0) begin
      dt   = rv - (longint'(cal_regs[REG_TREF_C5]) << 8);
      t    = TempRef + ((dt * longint'(cal_regs[REG_TEMPS_C6])) >>> 23);
      off  = (longint'(cal_regs[REG_OFF_C2]) << 16)
           + ((longint'(cal_regs[REG_TCO_C4]) * dt) >>> 7);
      sens = (longint'(cal_regs[REG_SENS_C1]) << 15)
           + ((longint'(cal_regs[REG_TCS_C3]) * dt) >>> 8);
      if (t < TempRef) begin
        // Both squares use the temperature before T2 comes off.
        t2    = (dt * dt) >>> 31;
        d     = t - TempRef;
        f     = d * d;
        off2  = (5 * f) >>> 1;
        sens2 = (5 * f) >>> 2;
        if (t < TempVeryLow) begin
          e     = t - TempVeryLow;
          f2    = e * e;
          off2  = off2 + 7 * f2;
          sens2 = sens2 + ((11 * f2) >>> 1);
        end
        t    = t - t2;
        off  = off - off2;
        sens = sens - sens2;
      end
      held_temp = t;
      held_off  = off;
      held_sens = sens;
    end else begin
      p = (((rv * held_sens) >>> 21) - held_off) >>> 15;
      r.pressure_valid = 1'b1;
    end
    model_phase = (model_phase + 1) % (PressurePerTemp + 1);
    r.temperature_centi   = held_temp[TempW-1:0];
    r.pressure_centi      = p[PresW-1:0];
    r.next_is_temperature = (model_phase == 0);
    return r;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    mismatches++;
    if (mismatches <= MaxReported)
      $display("tb: mismatch in %s at cycle %0d: got %0h, want %0h", what, cycles, got, want);
  endtask

  // Result checker: every accepted word against the oldest expectation.
  always @(posedge clk_i) begin : result_check
    baro_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_readouts.size() == 0) begin
        report("unexpected word", m_axis_tdata, '0);
      end else begin
        want = pending_readouts.pop_front();
        if (m_axis_tuser[0] !== want.pressure_valid)
          report("pressure_valid", m_axis_tuser[0], want.pressure_valid);
        if (m_axis_tdata[18:0] !== want.temperature_centi)
          report("temperature_centi", m_axis_tdata[18:0], want.temperature_centi);
        if (m_axis_tdata[50:19] !== want.pressure_centi)
          report("pressure_centi", m_axis_tdata[50:19], want.pressure_centi);
        if (m_axis_tdata[51] !== want.next_is_temperature)
          report("next_is_temperature", m_axis_tdata[51], want.next_is_temperature);
        if (m_axis_tdata[55:52] !== 4'h0)
          report("tdata padding", m_axis_tdata[55:52], 4'h0);
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin : sink
    int unsigned n;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk_i);
      end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
        n = $urandom_range(12, 1);
        m_axis_tready <= 1'b0;
        repeat (n - 1) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Sender gap: the bus carries junk while tvalid is low.
  task automatic pause_sender(input int unsigned n);
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= RawW'($urandom);
    repeat (n) @(posedge clk_i);
  endtask

  // Offers one reading and returns at the edge that takes it.
  task automatic send_reading(input logic [RawW-1:0] raw, input bit typed,
                              input baro_result_t typed_res);
    baro_result_t r;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= raw;
    do @(posedge clk_i); while (!s_axis_tready);
    r = compensate_reading(raw);
    pending_readouts.push_back(typed ? typed_res : r);
    words_in++;
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) pause_sender($urandom_range(12, 1));
  endtask

  // Waits until every result has come back, so the block is idle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_readouts.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CalW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    if (idx <= REG_TEMPS_C6) cal_regs[idx] = data;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Temperature words land near the reference half the time so that both cold corrections occur.
  function automatic logic [RawW-1:0] pick_raw();
    int unsigned sel;
    longint      v;
    sel = $urandom_range(99);
    if (sel < 10) begin
      v = sel[0] ? longint'(24'hFFFFFF) : 0;
    end else if (model_phase == 0 && sel < 60) begin
      v = (longint'(cal_regs[REG_TREF_C5]) << 8) + longint'($urandom_range(1 << 22))
        - (1 << 21);
      if (v < 0) v = 0;
      if (v > longint'(24'hFFFFFF)) v = longint'(24'hFFFFFF);
    end else if (sel < 15) begin
      v = sel[0] ? longint'(24'h800000) : longint'(24'h7FFFFF);
    end else begin
      v = longint'($urandom_range(24'hFFFFFF));
    end
    return v[RawW-1:0];
  endfunction

  function automatic row_t wr(input logic [CfgIdxW-1:0] idx, input logic [CalW-1:0] data);
    row_t r;
    r       = '{kind: ROW_WRITE, idx: idx, data: data, raw: '0, typed: 1'b0, res: '{default: '0}};
    return r;
  endfunction

  function automatic row_t rd(input logic [RawW-1:0] raw);
    row_t r;
    r       = '{kind: ROW_READING, idx: '0, data: '0, raw: raw, typed: 1'b0,
                res: '{default: '0}};
    return r;
  endfunction

  function automatic row_t rdx(input logic [RawW-1:0] raw, input logic pv, input int temp,
                               input int pres, input logic nxt);
    row_t r;
    r       = rd(raw);
    r.typed = 1'b1;
    r.res   = '{pressure_valid: pv, temperature_centi: temp[TempW-1:0],
                pressure_centi: pres[PresW-1:0], next_is_temperature: nxt};
    return r;
  endfunction

  initial begin : stimulus
    int unsigned ph;
    int unsigned k;
    logic [CalW-1:0] v;
    for (int i = 0; i < NumCal; i++) cal_regs[i] = '0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;

    dir_rows = '{
      // Zero calibration after reset: temperature sits at 20.00 C, pressure reads zero.
      rdx(24'h000000, 1'b0, TempRef, 0, 1'b0),
      rdx(24'hFFFFFF, 1'b1, TempRef, 0, 1'b0),
      rdx(24'h555555, 1'b1, TempRef, 0, 1'b0),
      rdx(24'hAAAAAA, 1'b1, TempRef, 0, 1'b1),
      // Typical factory coefficients; exactly 20.00 C, then just below it.
      wr(REG_SENS_C1, 16'd40127), wr(REG_OFF_C2, 16'd36924), wr(REG_TCS_C3, 16'd23317),
      wr(REG_TCO_C4, 16'd23282), wr(REG_TREF_C5, 16'd33464), wr(REG_TEMPS_C6, 16'd28312),
      rd(24'd8566784), rd(24'd8077636), rd(24'h000000), rd(24'hFFFFFF),
      rd(24'd8566783), rd(24'd8077636), rd(24'h800000), rd(24'h7FFFFF),
      // Very low temperature, below -15.00 C.
      rd(24'd7381584), rd(24'd8077636), rd(24'h000001), rd(24'hFFFFFE),
      // All coefficients at full scale; writes to the spare indexes must be ignored.
      wr(REG_SENS_C1, 16'hFFFF), wr(REG_OFF_C2, 16'hFFFF), wr(REG_TCS_C3, 16'hFFFF),
      wr(REG_TCO_C4, 16'hFFFF), wr(REG_TREF_C5, 16'hFFFF), wr(REG_TEMPS_C6, 16'hFFFF),
      wr(RegSpareLo, 16'h0000), wr(RegSpareHi, 16'h0000),
      rd(24'h000000), rd(24'h000000), rd(24'hFFFFFF), rd(24'h555555),
      // Hottest case: zero reference with full-scale temperature coefficient.
      wr(REG_TREF_C5, 16'h0000),
      rd(24'hFFFFFF), rd(24'hFFFFFF), rd(24'hAAAAAA), rd(24'h000000)
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part.
    gap_pct   = 20;
    stall_pct = 20;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        if (i == 0 || dir_rows[i - 1].kind != ROW_WRITE) drain();
        cfg_write(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_reading(dir_rows[i].raw, dir_rows[i].typed, dir_rows[i].res);
      end
    end

    // Random part: one calibration setting per phase, idling varied per phase.
    for (ph = 0; ph < RandPhases; ph++) begin
      drain();
      for (int r = 0; r < NumCal; r++) begin
        case (ph)
          1:       v = 16'hFFFF;
          2:       v = 16'h0000;
          default: v = CalW'($urandom_range(16'hFFFF));
        endcase
        if (ph == 4 && r == REG_TEMPS_C6) v = 16'hFFFF;
        cfg_write(CfgIdxW'(r), v);
      end
      if (ph == 5) begin
        cfg_write(RegSpareLo, CalW'($urandom));
        cfg_write(RegSpareHi, CalW'($urandom));
      end
      case (ph)
        0:       begin gap_pct = 25; stall_pct = 25; end
        1:       begin gap_pct = 10; stall_pct = 40; end
        2:       begin gap_pct = 40; stall_pct = 10; end
        3:       begin gap_pct = 0;  stall_pct = 0;  hold_req = 1'b1; end
        4:       begin gap_pct = 0;  stall_pct = 30; end
        5:       begin gap_pct = 30; stall_pct = 0;  end
        6:       begin gap_pct = 15; stall_pct = 15; end
        default: begin gap_pct = 0;  stall_pct = 0;  end
      endcase
      for (k = 0; k < PhaseWords; k++) send_reading(pick_raw(), 1'b0, '{default: '0});
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
